FILE: rtl/core/mrr_pkg.sv
`default_nettype none

package mrr_pkg;

  // field and register widths
  localparam int COORD_W  = 8;
  localparam int DIM_W    = 9;
  localparam int VAL_W    = 32;
  localparam int STEP_W   = 32;
  localparam int CNT_W    = $clog2(STEP_W);
  localparam int RING_W   = 7;
  localparam int LEN_W    = 10;
  localparam int CFG_IDX_W = 2;

  // largest matrix side that a coordinate can address
  localparam int COORD_SPAN = 256;
  localparam int DEFAULT_MAX_DIM = 256;

  // reset values of the registers
  localparam logic [DIM_W-1:0]  ROWS_RST  = DIM_W'(2);
  localparam logic [DIM_W-1:0]  COLS_RST  = DIM_W'(2);
  localparam logic [STEP_W-1:0] STEPS_RST = '0;

  // depth of the queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS  = 2'd0,
    CFG_COLS  = 2'd1,
    CFG_STEPS = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MAP
  } back_state_t;

  // one classified element on its way from front to back
  typedef struct packed {
    logic                     bad;
    logic [COORD_W-1:0]       src_row;
    logic [COORD_W-1:0]       src_col;
    logic signed [VAL_W-1:0]  value;
    logic [RING_W-1:0]        ring;
    logic [DIM_W-1:0]         h;
    logic [DIM_W-1:0]         w;
    logic [LEN_W-1:0]         len;
    logic [LEN_W-1:0]         pos;
  } job_t;

endpackage

`default_nettype wire

FILE: rtl/core/mrr_if.sv
`default_nettype none

interface mrr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [mrr_pkg::COORD_W-1:0]           src_row;
  logic [mrr_pkg::COORD_W-1:0]           src_col;
  logic signed [mrr_pkg::VAL_W-1:0]      elem_value;

  modport source (output valid, output src_row, output src_col, output elem_value,
                  input ready);
  modport sink   (input valid, input src_row, input src_col, input elem_value,
                  output ready);
endinterface

interface mrr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [mrr_pkg::COORD_W-1:0]           dest_row;
  logic [mrr_pkg::COORD_W-1:0]           dest_col;
  logic signed [mrr_pkg::VAL_W-1:0]      out_value;
  logic                                  bad_coord;

  modport source (output valid, output dest_row, output dest_col, output out_value,
                  output bad_coord, input ready);
  modport sink   (input valid, input dest_row, input dest_col, input out_value,
                  input bad_coord, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/matrix_ring_rotate_address.sv
// channel  | dir | handshake     | payload
// in_chan  | in  | valid/ready   | src_row, src_col, elem_value
// out_chan | out | valid/ready   | dest_row, dest_col, out_value, bad_coord
// cfg      | in  | cfg_we        | cfg_idx, cfg_data
//
// the back end handles one element at a time: a moved element is taken, run through
// 32 single-bit steps of rotation_steps mod ring length and mapped; a flagged one
// is taken and mapped; a two-entry queue lets the front keep taking beats
// reset (rst_n low, synchronous) empties the queue and result register and loads
// row_count = col_count = 2, rotation_steps = 0
// a stalled result stalls the back end; the front stalls only once the queue is full
`default_nettype none

module matrix_ring_rotate_address #(
  parameter int MAX_DIM = mrr_pkg::DEFAULT_MAX_DIM
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [mrr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [mrr_pkg::STEP_W-1:0]    cfg_data,
  mrr_in_if.sink                             in_chan,
  mrr_out_if.source                          out_chan
);

  logic [mrr_pkg::DIM_W-1:0]  rows_r, rows_nxt, cols_r, cols_nxt;
  logic [mrr_pkg::STEP_W-1:0] steps_r, steps_nxt;
  logic                       q_full, q_push, q_pop, q_empty;
  mrr_pkg::job_t              push_job, head_job;

  // configuration register writes
  always_comb begin
    rows_nxt  = rows_r;
    cols_nxt  = cols_r;
    steps_nxt = steps_r;
    if (cfg_we) begin
      unique case (mrr_pkg::cfg_idx_t'(cfg_idx))
        mrr_pkg::CFG_ROWS:  rows_nxt  = cfg_data[mrr_pkg::DIM_W-1:0];
        mrr_pkg::CFG_COLS:  cols_nxt  = cfg_data[mrr_pkg::DIM_W-1:0];
        mrr_pkg::CFG_STEPS: steps_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= mrr_pkg::ROWS_RST;
      cols_r  <= mrr_pkg::COLS_RST;
      steps_r <= mrr_pkg::STEPS_RST;
    end else begin
      rows_r  <= rows_nxt;
      cols_r  <= cols_nxt;
      steps_r <= steps_nxt;
    end
  end

  // classify incoming beats
  mrr_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .row_count (rows_r),
    .col_count (cols_r),
    .in_ch     (in_chan),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // queue between front and back
  mrr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_job)
  );

  // rotate and drive results
  mrr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rotation_steps (steps_r),
    .q_empty        (q_empty),
    .q_head         (head_job),
    .q_pop          (q_pop),
    .out_ch         (out_chan)
  );

endmodule

`default_nettype wire

FILE: rtl/core/mrr_front.sv
`default_nettype none

module mrr_front #(
  parameter int MAX_DIM = mrr_pkg::DEFAULT_MAX_DIM
) (
  input  wire logic [mrr_pkg::DIM_W-1:0] row_count,
  input  wire logic [mrr_pkg::DIM_W-1:0] col_count,
  mrr_in_if.sink                         in_ch,
  input  wire logic                      q_full,
  output      logic                      q_push,
  output      mrr_pkg::job_t             q_job
);

  localparam int DIM_LIM = (MAX_DIM < mrr_pkg::COORD_SPAN) ? MAX_DIM : mrr_pkg::COORD_SPAN;
  localparam logic [mrr_pkg::DIM_W-1:0] LIM = mrr_pkg::DIM_W'(DIM_LIM);

  logic [mrr_pkg::DIM_W-1:0]   rows, cols, h, w;
  logic [mrr_pkg::COORD_W-1:0] row, col, dist_bot, dist_rgt, dmin_r, dmin_c, d, lr, lc;
  logic [mrr_pkg::LEN_W-1:0]   h10, w10, lr10, lc10, pos;
  logic [mrr_pkg::LEN_W:0]     len_wide;
  logic                        outside, thin;

  // beat is taken whenever the queue has room
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // clamp dimensions and check the coordinate
  always_comb begin
    row  = in_ch.src_row;
    col  = in_ch.src_col;
    rows = (row_count > LIM) ? LIM : row_count;
    cols = (col_count > LIM) ? LIM : col_count;
    outside = ({1'b0, row} >= rows) || ({1'b0, col} >= cols);
  end

  // ring index is the least distance to an edge
  always_comb begin
    dist_bot = mrr_pkg::COORD_W'(rows - mrr_pkg::DIM_W'(1) - {1'b0, row});
    dist_rgt = mrr_pkg::COORD_W'(cols - mrr_pkg::DIM_W'(1) - {1'b0, col});
    dmin_r   = (row < dist_bot) ? row : dist_bot;
    dmin_c   = (col < dist_rgt) ? col : dist_rgt;
    d        = (dmin_r < dmin_c) ? dmin_r : dmin_c;
    h        = rows - {d, 1'b0};
    w        = cols - {d, 1'b0};
    thin     = (h < mrr_pkg::DIM_W'(2)) || (w < mrr_pkg::DIM_W'(2));
    lr       = row - d;
    lc       = col - d;
    len_wide = {1'b0, h, 1'b0} + {1'b0, w, 1'b0} - (mrr_pkg::LEN_W+1)'(4);
  end

  // position along the ring, counter-clockwise from the top-left corner
  always_comb begin
    h10  = {1'b0, h};
    w10  = {1'b0, w};
    lr10 = {2'b0, lr};
    lc10 = {2'b0, lc};
    if (lc == '0) begin
      pos = lr10;
    end else if ({1'b0, lr} == h - mrr_pkg::DIM_W'(1)) begin
      pos = h10 - mrr_pkg::LEN_W'(1) + lc10;
    end else if ({1'b0, lc} == w - mrr_pkg::DIM_W'(1)) begin
      pos = h10 + w10 - mrr_pkg::LEN_W'(2) + (h10 - mrr_pkg::LEN_W'(1) - lr10);
    end else begin
      pos = {h, 1'b0} + w10 - mrr_pkg::LEN_W'(3) + (w10 - mrr_pkg::LEN_W'(1) - lc10);
    end
  end

  // classified job for the queue
  always_comb begin
    q_job.bad     = outside || thin;
    q_job.src_row = row;
    q_job.src_col = col;
    q_job.value   = in_ch.elem_value;
    q_job.ring    = d[mrr_pkg::RING_W-1:0];
    q_job.h       = h;
    q_job.w       = w;
    q_job.len     = len_wide[mrr_pkg::LEN_W-1:0];
    q_job.pos     = pos;
  end

endmodule

`default_nettype wire

FILE: rtl/core/mrr_queue.sv
`default_nettype none

module mrr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mrr_pkg::job_t push_job,
  output      logic          full,
  input  wire logic          pop,
  output      logic          empty,
  output      mrr_pkg::job_t head
);

  mrr_pkg::job_t                mem_r [mrr_pkg::Q_DEPTH];
  logic [mrr_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [mrr_pkg::Q_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign full  = (cnt_r == mrr_pkg::Q_CNT_W'(mrr_pkg::Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == mrr_pkg::Q_PTR_W'(mrr_pkg::Q_DEPTH - 1)) ? '0 :
                   wr_ptr_r + mrr_pkg::Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mrr_pkg::Q_PTR_W'(mrr_pkg::Q_DEPTH - 1)) ? '0 :
                   rd_ptr_r + mrr_pkg::Q_PTR_W'(1);
    end
    cnt_nxt = cnt_r + mrr_pkg::Q_CNT_W'(do_push) - mrr_pkg::Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mrr_back.sv
`default_nettype none

module mrr_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [mrr_pkg::STEP_W-1:0] rotation_steps,
  input  wire logic                       q_empty,
  input  wire mrr_pkg::job_t              q_head,
  output      logic                       q_pop,
  mrr_out_if.source                       out_ch
);

  mrr_pkg::back_state_t          state_r, state_nxt;
  mrr_pkg::job_t                 job_r, job_nxt;
  logic [mrr_pkg::LEN_W-1:0]     rem_r, rem_nxt;
  logic [mrr_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                          out_vld_r, out_vld_nxt;
  logic [mrr_pkg::COORD_W-1:0]   drow_r, drow_nxt, dcol_r, dcol_nxt;
  logic signed [mrr_pkg::VAL_W-1:0] oval_r, oval_nxt;
  logic                          obad_r, obad_nxt;

  logic [mrr_pkg::LEN_W:0]       cand, sum, t2, t3;
  logic [mrr_pkg::LEN_W-1:0]     div_rem, q, h10, w10, d10, nr, nc, rrow, rcol;

  assign out_ch.valid     = out_vld_r;
  assign out_ch.dest_row  = drow_r;
  assign out_ch.dest_col  = dcol_r;
  assign out_ch.out_value = oval_r;
  assign out_ch.bad_coord = obad_r;

  // one restoring step of rotation_steps mod len
  always_comb begin
    cand    = {rem_r, rotation_steps[cnt_r]};
    div_rem = (cand >= {1'b0, job_r.len}) ? mrr_pkg::LEN_W'(cand - {1'b0, job_r.len}) :
              cand[mrr_pkg::LEN_W-1:0];
  end

  // destination on the ring
  always_comb begin
    h10 = {1'b0, job_r.h};
    w10 = {1'b0, job_r.w};
    d10 = {3'b0, job_r.ring};
    sum = {1'b0, job_r.pos} + {1'b0, rem_r};
    q   = (sum >= {1'b0, job_r.len}) ? mrr_pkg::LEN_W'(sum - {1'b0, job_r.len}) :
          sum[mrr_pkg::LEN_W-1:0];
    t2  = {1'b0, h10} + {1'b0, w10} - (mrr_pkg::LEN_W+1)'(1);
    t3  = {1'b0, job_r.h, 1'b0} + {1'b0, w10} - (mrr_pkg::LEN_W+1)'(2);
    if (q < h10) begin
      nr = q;
      nc = '0;
    end else if ({1'b0, q} < t2) begin
      nr = h10 - mrr_pkg::LEN_W'(1);
      nc = q - (h10 - mrr_pkg::LEN_W'(1));
    end else if ({1'b0, q} < t3) begin
      nr = t3[mrr_pkg::LEN_W-1:0] - mrr_pkg::LEN_W'(1) - q;
      nc = w10 - mrr_pkg::LEN_W'(1);
    end else begin
      nr = '0;
      nc = job_r.len - q;
    end
    rrow = nr + d10;
    rcol = nc + d10;
  end

  // sequencer: take a job, divide, place the result beat
  always_comb begin
    state_nxt   = state_r;
    job_nxt     = job_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    q_pop       = 1'b0;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    drow_nxt    = drow_r;
    dcol_nxt    = dcol_r;
    oval_nxt    = oval_r;
    obad_nxt    = obad_r;
    unique case (state_r)
      mrr_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_head;
          rem_nxt   = '0;
          cnt_nxt   = '1;
          state_nxt = q_head.bad ? mrr_pkg::BK_MAP : mrr_pkg::BK_DIV;
        end
      end
      mrr_pkg::BK_DIV: begin
        rem_nxt = div_rem;
        cnt_nxt = cnt_r - mrr_pkg::CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = mrr_pkg::BK_MAP;
        end
      end
      mrr_pkg::BK_MAP: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          oval_nxt    = job_r.value;
          obad_nxt    = job_r.bad;
          drow_nxt    = job_r.bad ? job_r.src_row : rrow[mrr_pkg::COORD_W-1:0];
          dcol_nxt    = job_r.bad ? job_r.src_col : rcol[mrr_pkg::COORD_W-1:0];
          state_nxt   = mrr_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = mrr_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mrr_pkg::BK_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    drow_r <= drow_nxt;
    dcol_r <= dcol_nxt;
    oval_r <= oval_nxt;
    obad_r <= obad_nxt;
  end

`ifndef SYNTH
  // partial remainder stays below the ring length
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrr_pkg::BK_DIV) |-> (rem_r < job_r.len))
    else $error("remainder not below ring length");

  // division only ends into the mapping step
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrr_pkg::BK_DIV) |=>
      (state_r == mrr_pkg::BK_DIV || state_r == mrr_pkg::BK_MAP))
    else $error("division left early");

  // a result beat appears only out of the mapping step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == mrr_pkg::BK_MAP))
    else $error("result beat without mapping step");
`endif

endmodule

`default_nettype wire
